[src/dmsht_pkg.sv]
package dmsht_pkg;

    // table geometry: the entry index is the low bits of the index hash,
    // so the entry count stays a power of two
    localparam int TABLE_ENTRIES = 1024;
    localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
    localparam int LENGTH_BITS   = 16;

    // key and hash widths
    localparam int HASH_BITS  = 64;
    localparam int ELEM_BITS  = 32;
    localparam int VALUE_BITS = 32;

    // hash seeds
    localparam logic [HASH_BITS-1:0] INDEX_SEED = 64'd123456789;
    localparam logic [HASH_BITS-1:0] CHECK_SEED = 64'd987654321;

    // key operation carried in tuser with the last element
    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_FIND   = 1'b1
    } func_t;

    // one table entry
    typedef struct packed {
        logic [HASH_BITS-1:0]   check;
        logic [LENGTH_BITS-1:0] length;
        logic [VALUE_BITS-1:0]  value;
    } entry_t;

    // access request to the table
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [INDEX_BITS-1:0] addr;
        entry_t                wr_entry;
    } table_req_t;

endpackage

[src/dmsht_table.sv]
module dmsht_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmsht_pkg::table_req_t  req,
    output dmsht_pkg::entry_t      rd_entry,
    output logic                   clearing
);
    import dmsht_pkg::*;

    entry_t                mem [TABLE_ENTRIES];
    entry_t                rd_entry_reg;
    logic                  clearing_reg;
    logic [INDEX_BITS-1:0] clear_addr_reg;

    // clearing sweep after reset, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == INDEX_BITS'(TABLE_ENTRIES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    // single-port memory with registered read data
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_entry_reg <= mem[req.addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign clearing = clearing_reg;

endmodule

[src/direct_mapped_sequence_hash_table.sv]
// A find result: the table is read at the edge that takes its last element, and
// the compare then loads the output register as soon as that register is free to
// take it.
// Throughput: one key element per cycle; after the last element of a find the
// input holds off until the pending lookup has moved into the output register.
// Reset: the hashes return to their seeds and the length to zero; the table is
// then cleared by a sweep over all 1024 entries, one entry per cycle, during which no element is taken.
module direct_mapped_sequence_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key_element [31:0], store_value [63:32]
    input  logic        s_axis_tuser,   // func
    input  logic        s_axis_tlast,   // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // found_value [31:0]
    output logic        m_axis_tuser    // hit
);
    import dmsht_pkg::*;

    // one unfinished one-at-a-time mixing step
    function automatic logic [HASH_BITS-1:0] mix_step(
        input logic [HASH_BITS-1:0] h,
        input logic [ELEM_BITS-1:0] x
    );
        logic [HASH_BITS-1:0] s;
        s = h + {{(HASH_BITS - ELEM_BITS){x[ELEM_BITS-1]}}, x};
        s = s + (s << 10);
        return s ^ (s >> 6);
    endfunction

    logic [ELEM_BITS-1:0]   key_element;
    logic [VALUE_BITS-1:0]  store_value;
    func_t                  func;
    logic                   in_accept;
    logic                   key_done;
    logic                   out_free;
    logic                   clearing;

    logic [HASH_BITS-1:0]   index_hash_reg;
    logic [HASH_BITS-1:0]   check_hash_reg;
    logic [LENGTH_BITS-1:0] key_length_reg;
    logic [HASH_BITS-1:0]   index_hash_next;
    logic [HASH_BITS-1:0]   check_hash_next;
    logic [LENGTH_BITS-1:0] key_length_next;

    logic                   lookup_valid_reg;
    logic [HASH_BITS-1:0]   lookup_check_reg;
    logic [LENGTH_BITS-1:0] lookup_length_reg;

    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [VALUE_BITS-1:0]  found_value_reg;

    table_req_t             req;
    entry_t                 rd_entry;

    // request fields
    assign key_element = s_axis_tdata[ELEM_BITS-1:0];
    assign store_value = s_axis_tdata[ELEM_BITS +: VALUE_BITS];
    assign func        = func_t'(s_axis_tuser);

    // handshake; a pending lookup holds off the input until it reaches the output
    assign s_axis_tready = !clearing && !lookup_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign key_done      = in_accept && s_axis_tlast;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // hash and saturating length update for the current element
    assign index_hash_next = mix_step(index_hash_reg, key_element);
    assign check_hash_next = mix_step(check_hash_reg, key_element);
    assign key_length_next = (key_length_reg == '1) ? key_length_reg
                                                    : key_length_reg + 1'b1;

    // table access on the last element
    always_comb
    begin
        req.wr_en           = key_done && (func == FUNC_INSERT);
        req.rd_en           = key_done && (func == FUNC_FIND);
        req.addr            = index_hash_next[INDEX_BITS-1:0];
        req.wr_entry.check  = check_hash_next;
        req.wr_entry.length = key_length_next;
        req.wr_entry.value  = store_value;
    end

    dmsht_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rd_entry (rd_entry),
        .clearing (clearing)
    );

    // running key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_hash_reg <= INDEX_SEED;
            check_hash_reg <= CHECK_SEED;
            key_length_reg <= '0;
        end
        else if (in_accept)
        begin
            if (s_axis_tlast)
            begin
                index_hash_reg <= INDEX_SEED;
                check_hash_reg <= CHECK_SEED;
                key_length_reg <= '0;
            end
            else
            begin
                index_hash_reg <= index_hash_next;
                check_hash_reg <= check_hash_next;
                key_length_reg <= key_length_next;
            end
        end
    end

    // lookup and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                lookup_valid_reg <= 1'b1;
            end
            else if (lookup_valid_reg && out_free)
            begin
                lookup_valid_reg <= 1'b0;
            end

            if (lookup_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // lookup key and result payload
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            lookup_check_reg  <= check_hash_next;
            lookup_length_reg <= key_length_next;
        end
        if (lookup_valid_reg && out_free)
        begin
            if (rd_entry.length == lookup_length_reg && rd_entry.check == lookup_check_reg)
            begin
                hit_reg         <= 1'b1;
                found_value_reg <= rd_entry.value;
            end
            else
            begin
                hit_reg         <= 1'b0;
                found_value_reg <= '1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = found_value_reg;

    // no element is taken while the table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("element taken during table clear");

    // a pending lookup blocks further elements
    assert property (@(posedge clk) disable iff (!rst_n)
        lookup_valid_reg |-> !in_accept)
        else $error("element taken while lookup pending");

    // a completed find always leaves a pending lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |=> lookup_valid_reg)
        else $error("find did not start a lookup");

    // a completed key restarts the hashes and the length
    assert property (@(posedge clk) disable iff (!rst_n)
        key_done |=> (index_hash_reg == INDEX_SEED && check_hash_reg == CHECK_SEED
                      && key_length_reg == '0))
        else $error("key state not restarted after last element");

endmodule

[tb/direct_mapped_sequence_hash_table_tb.sv]
`timescale 1ns / 1ps

module direct_mapped_sequence_hash_table_tb;

    import dmsht_pkg::*;

    localparam int          IDLE_PERCENT  = 24;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          POOL_KEYS     = 16;
    localparam int          POOL_MAX_LEN  = 8;
    localparam int          LONG_KEY_LEN  = (1 << LENGTH_BITS) + 1;
    localparam int          DRAIN_CYCLES  = 8;
    localparam longint      CYCLE_LIMIT   = 1_500_000;
    localparam logic [31:0] MISS_VALUE    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } lookup_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    // shadow of the key hashing state and the table
    logic [HASH_BITS-1:0]   sh_index_hash;
    logic [HASH_BITS-1:0]   sh_check_hash;
    logic [LENGTH_BITS-1:0] sh_key_length;
    logic [HASH_BITS-1:0]   sh_entry_check [TABLE_ENTRIES];
    logic [LENGTH_BITS-1:0] sh_entry_length [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0]  sh_entry_value [TABLE_ENTRIES];

    lookup_t          pending_lookups [$];
    logic [31:0]      key_buf [$];
    logic [31:0]      pool_elems [POOL_KEYS][POOL_MAX_LEN];
    int               pool_len [POOL_KEYS];
    int               elements_sent = 0;
    int               mismatch_count = 0;
    longint           cycle_count = 0;
    logic             no_idle = 1'b0;

    direct_mapped_sequence_hash_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // one-at-a-time mixing step without the final avalanche
    function automatic logic [HASH_BITS-1:0] oaat_mix(input logic [HASH_BITS-1:0] h,
                                                      input logic [31:0] x);
        logic [HASH_BITS-1:0] ext;
        ext = {{(HASH_BITS - 32){x[31]}}, x};
        h = h + ext;
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    // table slot that the key in key_buf maps to
    function automatic logic [INDEX_BITS-1:0] key_slot();
        logic [HASH_BITS-1:0] h;
        h = INDEX_SEED;
        foreach (key_buf[i])
            h = oaat_mix(h, key_buf[i]);
        return INDEX_BITS'(h % TABLE_ENTRIES);
    endfunction

    // element values weighted toward the extremes
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic restart_shadow_key();
        sh_index_hash = INDEX_SEED;
        sh_check_hash = CHECK_SEED;
        sh_key_length = '0;
    endtask

    // advance the shadow table by one accepted element
    task automatic apply_key_element(input logic func, input logic [31:0] elem,
                                     input logic last, input logic [31:0] val);
        logic [INDEX_BITS-1:0] slot;
        lookup_t               res;
        sh_index_hash = oaat_mix(sh_index_hash, elem);
        sh_check_hash = oaat_mix(sh_check_hash, elem);
        if (sh_key_length != {LENGTH_BITS{1'b1}})
            sh_key_length = sh_key_length + 1'b1;
        if (last)
        begin
            slot = INDEX_BITS'(sh_index_hash % TABLE_ENTRIES);
            if (func == FUNC_INSERT)
            begin
                sh_entry_check[slot]  = sh_check_hash;
                sh_entry_length[slot] = sh_key_length;
                sh_entry_value[slot]  = val;
            end
            else
            begin
                res.hit   = (sh_entry_length[slot] == sh_key_length) &&
                            (sh_entry_check[slot] == sh_check_hash);
                res.value = res.hit ? sh_entry_value[slot] : MISS_VALUE;
                pending_lookups.push_back(res);
            end
            restart_shadow_key();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // drive one element request and wait for it to be taken
    task automatic send_element(input logic func, input logic [31:0] elem,
                                input logic last, input logic [31:0] val);
        logic taken;
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, elem};
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        apply_key_element(func, elem, last, val);
        elements_sent++;
    endtask

    // stream key_buf as one key; func and value are noise except on the last element
    task automatic send_key(input logic func, input logic [31:0] val);
        int n;
        n = key_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                send_element(func, key_buf[i], 1'b1, val);
            else
                send_element(logic'($urandom_range(0, 1)), key_buf[i], 1'b0, $urandom());
        end
    endtask

    // result checker, sampled at the falling edge before the handshake edge
    always @(negedge clk)
    begin
        lookup_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result with no pending find, value", '0, m_axis_tdata);
            else
            begin
                want = pending_lookups.pop_front();
                if (m_axis_tuser !== want.hit)
                    report_mismatch("hit", 32'(want.hit), 32'(m_axis_tuser));
                if (m_axis_tdata !== want.value)
                    report_mismatch("found_value", want.value, m_axis_tdata);
            end
        end
    end

    // finds on a cleared table always miss
    task automatic test_empty_table();
        key_buf.delete();
        key_buf.push_back(32'h0000_0000);
        send_key(FUNC_FIND, 32'hFFFF_FFFF);
        key_buf.delete();
        key_buf.push_back(32'h8000_0000);
        key_buf.push_back(32'h7FFF_FFFF);
        send_key(FUNC_FIND, 32'h0000_0000);
    endtask

    // insert then find, extreme values, overwrite of the same key
    task automatic test_insert_find();
        key_buf.delete();
        key_buf.push_back(32'h7FFF_FFFF);
        send_key(FUNC_INSERT, 32'h7FFF_FFFF);
        send_key(FUNC_FIND, 32'h0000_0000);
        key_buf.delete();
        key_buf.push_back(32'h8000_0000);
        key_buf.push_back(32'h0000_0000);
        send_key(FUNC_INSERT, 32'h8000_0000);
        send_key(FUNC_FIND, 32'h7FFF_FFFF);
        // stored value of all ones on a hit looks like a miss value
        key_buf.delete();
        key_buf.push_back(32'hFFFF_FFFF);
        send_key(FUNC_INSERT, 32'hFFFF_FFFF);
        send_key(FUNC_FIND, 32'h1234_5678);
        send_key(FUNC_INSERT, 32'h0000_0000);
        send_key(FUNC_FIND, 32'hFFFF_FFFF);
    endtask

    // keys sharing a slot: check hash mismatch, length mismatch, eviction
    task automatic test_slot_collision();
        logic [31:0]           stored_elem;
        logic [31:0]           rival_elem;
        logic [INDEX_BITS-1:0] target;
        stored_elem = $urandom();
        key_buf.delete();
        key_buf.push_back(stored_elem);
        target = key_slot();
        send_key(FUNC_INSERT, 32'h1234_5678);
        // same slot and length, different element
        do
        begin
            key_buf.delete();
            key_buf.push_back($urandom());
        end
        while (key_slot() != target || key_buf[0] == stored_elem);
        rival_elem = key_buf[0];
        send_key(FUNC_FIND, $urandom());
        // same slot, different length
        do
        begin
            key_buf.delete();
            key_buf.push_back($urandom());
            key_buf.push_back($urandom());
        end
        while (key_slot() != target);
        send_key(FUNC_FIND, $urandom());
        // rival evicts the stored key
        key_buf.delete();
        key_buf.push_back(rival_elem);
        send_key(FUNC_INSERT, 32'h0BAD_CAFE);
        key_buf.delete();
        key_buf.push_back(stored_elem);
        send_key(FUNC_FIND, $urandom());
        key_buf.delete();
        key_buf.push_back(rival_elem);
        send_key(FUNC_FIND, $urandom());
    endtask

    // key longer than the length counter can count
    task automatic test_long_key();
        key_buf.delete();
        for (int i = 0; i < LONG_KEY_LEN; i++)
            key_buf.push_back(pick_element());
        send_key(FUNC_INSERT, $urandom());
        send_key(FUNC_FIND, $urandom());
    endtask

    // random mix over a small key pool so that finds often hit
    task automatic test_random_traffic();
        int start;
        int sel;
        int len;
        int op;
        for (int k = 0; k < POOL_KEYS; k++)
        begin
            pool_len[k] = (k < 3) ? 1 : $urandom_range(1, POOL_MAX_LEN);
            for (int j = 0; j < POOL_MAX_LEN; j++)
                pool_elems[k][j] = pick_element();
        end
        start = elements_sent;
        while (elements_sent < start + RANDOM_ITEMS)
        begin
            // back-to-back stretch in the middle
            no_idle = (elements_sent >= start + 350) && (elements_sent < start + 650);
            op = $urandom_range(0, 9);
            key_buf.delete();
            if (op < 8)
            begin
                sel = $urandom_range(0, POOL_KEYS - 1);
                for (int j = 0; j < pool_len[sel]; j++)
                    key_buf.push_back(pool_elems[sel][j]);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    key_buf.push_back(pick_element());
            end
            if (op < 4)
                send_key(FUNC_INSERT, pick_element());
            else
                send_key(FUNC_FIND, $urandom());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        restart_shadow_key();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            sh_entry_check[i]  = '0;
            sh_entry_length[i] = '0;
            sh_entry_value[i]  = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_insert_find();
        test_slot_collision();
        test_long_key();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
